FILE: design/vtd_pkg.sv
// shared types and constants for the viterbi tag decoder
`default_nettype none
package vtd_pkg;

  localparam int NUM_TAGS   = 64;
  localparam int MAX_TOKENS = 64;
  localparam int TAG_W      = $clog2(NUM_TAGS);
  localparam int POS_W      = $clog2(MAX_TOKENS);
  localparam int CNT_W      = TAG_W + 1;
  localparam int VAL_W      = 16;
  localparam int SCORE_W    = 32;
  localparam int MARGIN_W   = 15;
  localparam int ADD_W      = VAL_W + 2;
  localparam int SUM_W      = SCORE_W + 2;

  localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -32'sd2560000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX   = 32'sh7fffffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN   = 32'sh80000000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [TAG_W-1:0]        from_tag;
    logic [TAG_W-1:0]        tag;
    logic signed [VAL_W-1:0] score_value;
    logic [TAG_W-1:0]        gold_tag;
    logic                    token_end;
    logic                    sentence_end;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [TAG_W-1:0] label;
    logic             is_correct;
    logic             last;
  } out_item_t;

endpackage
`default_nettype wire

FILE: design/vtd_ram.sv
// simple dual port synchronous ram, registered read
`default_nettype none
module vtd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/viterbi_tag_decoder.sv
// top level of the viterbi tag decoder: sequencer and state memories
`default_nettype none
// Viterbi sequence-tag decoder. Load items (op 0) write one transition
// entry. An emission item (op 1) scores one tag: the first item of a token
// adds a pass that resets the token's score and back-pointer rows, then a
// pass over all previous path scores (a single entry on the first token of
// a sentence) reads one entry per cycle from the score memory and
// transition memory. busy is high while an item is in work. The item
// that closes a sentence adds a search for the best final tag and then
// the traceback, which reads the back-pointer memory and delivers one
// result per pass through its read and output states, last position
// first. Results appear for one cycle under out_strobe and cannot be held
// off. No clearing pass runs after reset. cfg_margin may be written
// whenever the block is idle.
module viterbi_tag_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vtd_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output vtd_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [14:0]        cfg_margin
);
  import vtd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SCORE, ST_FINISH, ST_SEARCH, ST_TRACE_RD, ST_TRACE_OUT
  } state_t;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_TAGS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TOKENS - 1);

  state_t                     state_r;
  in_item_t                   item_r;
  logic [MARGIN_W-1:0]        margin_r;
  logic [POS_W-1:0]           pos_r;
  logic [POS_W-1:0]           tp_r;
  logic [TAG_W-1:0]           lab_r;
  logic                       open_r;
  logic                       bank_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [TAG_W-1:0]           idx_d_r;
  logic                       rd_vld_r;
  logic signed [SCORE_W-1:0]  best_r;
  logic [TAG_W-1:0]           arg_r;
  logic                       out_strobe_r;
  out_item_t                  out_item_r;

  logic                       accept;
  logic [CNT_W-1:0]           kmax;
  logic                       issuing;
  logic signed [ADD_W-1:0]    add_val;
  logic signed [SCORE_W-1:0]  prev_val;
  logic signed [SUM_W-1:0]    sum_val;
  logic signed [SCORE_W-1:0]  cand;
  logic                       close_sent;

  // memory ports
  logic                       tr_we;
  logic [2*TAG_W-1:0]         tr_waddr, tr_raddr;
  logic [VAL_W-1:0]           tr_rdata;
  logic                       sc_we0, sc_we1;
  logic [TAG_W-1:0]           sc_waddr, sc_raddr;
  logic [SCORE_W-1:0]         sc_wdata, sc_rdata0, sc_rdata1;
  logic signed [SCORE_W-1:0]  prev_rdata, cur_rdata;
  logic                       bp_we;
  logic [POS_W+TAG_W-1:0]     bp_waddr, bp_raddr;
  logic [TAG_W-1:0]           bp_wdata, bp_rdata;
  logic                       gd_we;
  logic [TAG_W-1:0]           gd_rdata;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // transition table: written by load items, read along column j
  assign tr_we    = accept && (in_item.op == OP_LOAD);
  assign tr_waddr = {in_item.from_tag, in_item.tag};
  assign tr_raddr = (pos_r == '0) ? {{TAG_W{1'b0}}, item_r.tag}
                                  : {cnt_r[TAG_W-1:0], item_r.tag};

  vtd_ram #(.DEPTH(NUM_TAGS * NUM_TAGS), .WIDTH(VAL_W)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(in_item.score_value),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );

  // path score banks: bank_r is the current token, the other holds previous
  assign sc_we0   = ((state_r == ST_CLEAR) || (state_r == ST_FINISH)) && !bank_r;
  assign sc_we1   = ((state_r == ST_CLEAR) || (state_r == ST_FINISH)) && bank_r;
  assign sc_waddr = (state_r == ST_CLEAR) ? cnt_r[TAG_W-1:0] : item_r.tag;
  assign sc_wdata = (state_r == ST_CLEAR) ? SCORE_FLOOR : best_r;
  assign sc_raddr = cnt_r[TAG_W-1:0];
  assign prev_rdata = bank_r ? sc_rdata0 : sc_rdata1;
  assign cur_rdata  = bank_r ? sc_rdata1 : sc_rdata0;

  vtd_ram #(.DEPTH(NUM_TAGS), .WIDTH(SCORE_W)) u_bank0 (
    .clk(clk), .we(sc_we0), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata0)
  );

  vtd_ram #(.DEPTH(NUM_TAGS), .WIDTH(SCORE_W)) u_bank1 (
    .clk(clk), .we(sc_we1), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata1)
  );

  // back pointers, one row per position
  assign bp_we    = (state_r == ST_CLEAR) || (state_r == ST_FINISH);
  assign bp_waddr = (state_r == ST_CLEAR) ? {pos_r, cnt_r[TAG_W-1:0]} : {pos_r, item_r.tag};
  assign bp_wdata = (state_r == ST_CLEAR) ? '0 : arg_r;
  assign bp_raddr = {tp_r, lab_r};

  vtd_ram #(.DEPTH(MAX_TOKENS * NUM_TAGS), .WIDTH(TAG_W)) u_bp (
    .clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
    .raddr(bp_raddr), .rdata(bp_rdata)
  );

  // gold tag per position, last emission of the token wins
  assign gd_we = accept && (in_item.op == OP_EMIT);

  vtd_ram #(.DEPTH(MAX_TOKENS), .WIDTH(TAG_W)) u_gold (
    .clk(clk), .we(gd_we), .waddr(pos_r), .wdata(in_item.gold_tag),
    .raddr(tp_r), .rdata(gd_rdata)
  );

  // candidate score: previous path + transition + emission, plus margin when the tag is not the gold tag
  always_comb begin
    kmax    = (pos_r == '0) ? CNT_W'(1) : CNT_FULL;
    issuing = (cnt_r < kmax);
    add_val = ADD_W'(item_r.score_value);
    if (item_r.tag != item_r.gold_tag) begin
      add_val = add_val + ADD_W'(signed'({1'b0, margin_r}));
    end
    prev_val = (pos_r == '0) ? '0 : prev_rdata;
    sum_val  = SUM_W'(prev_val) + SUM_W'(signed'(tr_rdata)) + SUM_W'(add_val);
    if (sum_val > SUM_W'(SCORE_MAX)) begin
      cand = SCORE_MAX;
    end else if (sum_val < SUM_W'(SCORE_MIN)) begin
      cand = SCORE_MIN;
    end else begin
      cand = sum_val[SCORE_W-1:0];
    end
    close_sent = item_r.token_end && (item_r.sentence_end || (pos_r == POS_LAST));
  end

  // margin register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_margin;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      open_r       <= 1'b0;
      bank_r       <= 1'b0;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_item.op == OP_EMIT)) begin
            item_r   <= in_item;
            cnt_r    <= '0;
            rd_vld_r <= 1'b0;
            best_r   <= SCORE_FLOOR;
            arg_r    <= '0;
            state_r  <= open_r ? ST_SCORE : ST_CLEAR;
          end
        end
        // reset the token's score row and back-pointer row
        ST_CLEAR: begin
          if (cnt_r == CNT_W'(NUM_TAGS - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_SCORE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        // max over previous tags, one read per cycle
        ST_SCORE: begin
          rd_vld_r <= issuing;
          if (issuing) begin
            idx_d_r <= cnt_r[TAG_W-1:0];
            cnt_r   <= cnt_r + CNT_W'(1);
          end
          if (rd_vld_r && (cand > best_r)) begin
            best_r <= cand;
            arg_r  <= idx_d_r;
          end
          if (!issuing && !rd_vld_r) begin
            state_r <= ST_FINISH;
          end
        end
        // score and back pointer written by the memory ports
        ST_FINISH: begin
          open_r   <= !item_r.token_end;
          cnt_r    <= '0;
          rd_vld_r <= 1'b0;
          if (close_sent) begin
            tp_r    <= pos_r;
            pos_r   <= '0;
            state_r <= ST_SEARCH;
          end else begin
            if (item_r.token_end) begin
              bank_r <= !bank_r;
              pos_r  <= pos_r + POS_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        // best final tag, first strict maximum
        ST_SEARCH: begin
          rd_vld_r <= (cnt_r < CNT_FULL);
          if (cnt_r < CNT_FULL) begin
            idx_d_r <= cnt_r[TAG_W-1:0];
            cnt_r   <= cnt_r + CNT_W'(1);
          end
          if (rd_vld_r && ((idx_d_r == '0) || (cur_rdata > best_r))) begin
            best_r <= cur_rdata;
            arg_r  <= idx_d_r;
          end
          if ((cnt_r == CNT_FULL) && !rd_vld_r) begin
            lab_r   <= arg_r;
            state_r <= ST_TRACE_RD;
          end
        end
        ST_TRACE_RD: begin
          state_r <= ST_TRACE_OUT;
        end
        // deliver one position and step back along the path
        ST_TRACE_OUT: begin
          out_strobe_r          <= 1'b1;
          out_item_r.position   <= tp_r;
          out_item_r.label      <= lab_r;
          out_item_r.is_correct <= (gd_rdata == lab_r);
          out_item_r.last       <= (tp_r == '0);
          if (tp_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            lab_r   <= bp_rdata;
            tp_r    <= tp_r - POS_W'(1);
            state_r <= ST_TRACE_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/vtd_checker.sv
// port level checks for the viterbi tag decoder, bound to the top level
`default_nettype none
module vtd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire vtd_pkg::out_item_t out_item
);
  import vtd_pkg::*;

  // the final item of a run is for position zero
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> out_item.position == '0)
    else $error("last item not at position zero");

  // nothing follows the last item directly
  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |=> !out_strobe)
    else $error("item right after the last one");

  // traceback keeps the block busy and steps the position down by one per item
  a_trace_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> busy)
    else $error("idle in the middle of a traceback");

  a_trace_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> !out_strobe ##1
      (out_strobe && (out_item.position + POS_W'(1) == $past(out_item.position, 2))))
    else $error("traceback position step broken");

endmodule

bind viterbi_tag_decoder vtd_checker u_vtd_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_strobe(out_strobe), .out_item(out_item)
);
`default_nettype wire

FILE: sim/viterbi_tag_decoder_tb.sv
// self-checking testbench for the viterbi tag decoder: queued driver, strobe monitor, predictor
`default_nettype none
module viterbi_tag_decoder_tb;
  import vtd_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [14:0] cfg_margin;

  viterbi_tag_decoder i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_margin(cfg_margin)
  );

  // predictor state
  logic signed [15:0] trans_tab [NUM_TAGS*NUM_TAGS];
  logic signed [31:0] prev_sc [NUM_TAGS];
  logic signed [31:0] cur_sc [NUM_TAGS];
  logic [5:0] bptr [MAX_TOKENS*NUM_TAGS];
  logic [5:0] gold_mem [MAX_TOKENS];
  int unsigned tok_pos;
  bit tok_open;
  logic [14:0] margin_q;

  in_item_t pending_q [$];
  out_item_t labels_q [$];
  int errors;
  int cycles;

  // transition columns loaded in full; emissions only use these tags
  int loaded_cols [3] = '{0, 31, 63};

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return SCORE_MAX;
    if (v < -64'sd2147483648) return SCORE_MIN;
    return v[31:0];
  endfunction

  // model one accepted item and queue the labels it produces
  task automatic predict_labels(in_item_t it);
    longint add;
    logic signed [31:0] best, c;
    int arg, n, b, p;
    logic [5:0] lab [MAX_TOKENS];
    out_item_t r;
    if (it.op == OP_LOAD) begin
      trans_tab[it.from_tag*NUM_TAGS + it.tag] = it.score_value;
      return;
    end
    if (!tok_open) begin
      for (int i = 0; i < NUM_TAGS; i++) begin
        cur_sc[i] = SCORE_FLOOR;
        bptr[tok_pos*NUM_TAGS + i] = '0;
      end
      tok_open = 1'b1;
    end
    gold_mem[tok_pos] = it.gold_tag;
    add = longint'(it.score_value);
    if (it.tag != it.gold_tag) add += longint'(margin_q);
    if (tok_pos == 0) begin
      cur_sc[it.tag] = sat32(longint'(trans_tab[it.tag]) + add);
    end else begin
      best = SCORE_FLOOR;
      arg = 0;
      for (int k = 0; k < NUM_TAGS; k++) begin
        c = sat32(longint'(prev_sc[k]) + longint'(trans_tab[k*NUM_TAGS + it.tag]) + add);
        if (c > best) begin
          best = c;
          arg = k;
        end
      end
      cur_sc[it.tag] = best;
      bptr[tok_pos*NUM_TAGS + it.tag] = arg[5:0];
    end
    if (!it.token_end) return;
    tok_open = 1'b0;
    prev_sc = cur_sc;
    if (!it.sentence_end && tok_pos + 1 < MAX_TOKENS) begin
      tok_pos++;
      return;
    end
    n = tok_pos + 1;
    b = 0;
    for (int i = 1; i < NUM_TAGS; i++) if (cur_sc[i] > cur_sc[b]) b = i;
    lab[n-1] = b[5:0];
    for (int i = n - 1; i > 0; i--) lab[i-1] = bptr[i*NUM_TAGS + lab[i]];
    for (int i = 0; i < n; i++) begin
      p = n - 1 - i;
      r.position = p[5:0];
      r.label = lab[p];
      r.is_correct = (lab[p] == gold_mem[p]);
      r.last = (p == 0);
      labels_q = {labels_q, r};
    end
    tok_pos = 0;
  endtask

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver: pops pending items, random gap before each
  int gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      predict_labels(in_item);
      start <= 1'b0;
      gap <= int'($urandom_range(0, 13));
    end else if (!start) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_q.size() > 0 && !cfg_valid) begin
        in_item <= pending_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: compare each strobed label with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      if (labels_q.size() == 0) report("label with nothing expected");
      else begin
        out_item_t e;
        e = labels_q.pop_front();
        if (out_item.position !== e.position)
          report($sformatf("position %0d exp %0d", out_item.position, e.position));
        if (out_item.label !== e.label)
          report($sformatf("label %0d exp %0d pos %0d", out_item.label, e.label, e.position));
        if (out_item.is_correct !== e.is_correct)
          report($sformatf("is_correct %b exp %b pos %0d", out_item.is_correct,
                           e.is_correct, e.position));
        if (out_item.last !== e.last)
          report($sformatf("last %b exp %b pos %0d", out_item.last, e.last, e.position));
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > 4000000) begin
      $display("viterbi_tag_decoder_tb: errors");
      $finish;
    end
  end

  function automatic in_item_t mk(logic op, int fr, int tg, int val, int gold,
                                  logic te, logic se);
    in_item_t it;
    it.op = op;
    it.from_tag = fr[5:0];
    it.tag = tg[5:0];
    it.score_value = val[15:0];
    it.gold_tag = gold[5:0];
    it.token_end = te;
    it.sentence_end = se;
    return it;
  endfunction

  // load every source row of one destination column
  task automatic load_col(int tg, bit rnd, int fixed_val);
    for (int k = 0; k < NUM_TAGS; k++)
      pending_q = {pending_q, mk(OP_LOAD, k, tg, rnd ? $urandom_range(0, 65535) : fixed_val,
                                 $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)))};
  endtask

  // queue one sentence; emissions only for tags whose columns are loaded
  task automatic add_sentence(int ntok, int ntags, bit extreme);
    int tg, v;
    for (int t = 0; t < ntok; t++) begin
      for (int e = 0; e < ntags; e++) begin
        tg = loaded_cols[$urandom_range(0, 2)];
        v = extreme ? ($urandom_range(0, 1) ? 32767 : -32768) : $urandom_range(0, 65535);
        pending_q = {pending_q, mk(OP_EMIT, $urandom_range(0, 63), tg, v,
                                   $urandom_range(0, 1) ? tg : $urandom_range(0, 63),
                                   e == ntags - 1,
                                   (e == ntags - 1) ? (t == ntok - 1)
                                                    : 1'($urandom_range(0, 1)))};
      end
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start || busy || labels_q.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_margin(logic [14:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_margin <= m;
    do @(posedge clk); while (!cfg_ready);
    margin_q = m;
    cfg_valid <= 1'b0;
    cfg_margin <= 15'($urandom_range(0, 32767));
  endtask

  initial begin
    logic [14:0] margins [4];
    errors = 0;
    cycles = 0;
    tok_pos = 0;
    tok_open = 1'b0;
    margin_q = '0;
    for (int i = 0; i < NUM_TAGS*NUM_TAGS; i++) begin
      trans_tab[i] = '0;
      bptr[i] = '0;
    end
    for (int i = 0; i < NUM_TAGS; i++) begin
      prev_sc[i] = SCORE_FLOOR;
      cur_sc[i] = SCORE_FLOOR;
      gold_mem[i] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_margin = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // every column an emission can read is loaded before the first emission
    for (int c = 0; c < 3; c++) load_col(loaded_cols[c], 1'b1, 0);
    // out-of-range loads cannot be expressed at 6 bits; ignored marks ride on loads above
    drain();

    // directed: extremes of score, margin off, short sentences, lone sentence end
    add_sentence(1, 1, 1'b1);
    add_sentence(2, 3, 1'b1);
    pending_q = {pending_q, mk(OP_EMIT, 0, 63, -32768, 63, 1'b0, 1'b1)};
    pending_q = {pending_q, mk(OP_EMIT, 63, 0, 32767, 0, 1'b1, 1'b1)};
    drain();

    // overlong sentence closes at the last position, one token spills over
    write_margin(15'h7fff);
    add_sentence(MAX_TOKENS + 1, 1, 1'b0);
    drain();

    // random phases over several margins
    margins[0] = '0;
    margins[1] = 15'h7fff;
    margins[2] = 15'($urandom_range(1, 1000));
    margins[3] = 15'($urandom_range(0, 32767));
    for (int ph = 0; ph < 4; ph++) begin
      write_margin(margins[ph]);
      // rewrite some transitions with extremes
      for (int i = 0; i < 10; i++)
        pending_q = {pending_q, mk(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 1) ? 32767 : -32768, 0, 1'b1, 1'b1)};
      for (int s = 0; s < 8; s++)
        add_sentence($urandom_range(1, 4), $urandom_range(1, 2), $urandom_range(0, 5) == 0);
      drain();
    end

    if (errors == 0) begin
      $display("viterbi_tag_decoder_tb: clean");
    end else begin
      $display("viterbi_tag_decoder_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
